[design/rlhc_pkg.sv]
// Shared types, constants and helpers for the rainbow pixel controller.
`timescale 1ns / 1ps

package rlhc_pkg;

	localparam int unsigned HUE_W   = 9;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned CH_W    = 8;
	localparam int unsigned CFG_W   = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned W_W     = 13;  // weight up to 6000
	localparam int unsigned P_W     = 20;  // level * weight up to 600000
	localparam int unsigned MUL_W   = 18;
	localparam int unsigned PROD_W  = 2 * MUL_W;

	localparam logic [CFG_IDX_W-1:0] REG_HUE_STEP        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SATURATION      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_STEP = 2'd2;

	localparam logic [HUE_W-1:0] HUE_STEP_RST = 9'd2;
	localparam logic [PCT_W-1:0] SAT_RST      = 7'd100;
	localparam logic [PCT_W-1:0] BSTEP_RST    = 7'd10;
	localparam logic [PCT_W-1:0] LEVEL_RST    = 7'd20;
	localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;

	localparam logic [CH_W-1:0] CMD_TOGGLE_LC = 8'h61;  // 'a'
	localparam logic [CH_W-1:0] CMD_TOGGLE_UC = 8'h41;  // 'A'
	localparam logic [CH_W-1:0] CMD_DIM       = 8'h31;  // '1'
	localparam logic [CH_W-1:0] CMD_BRIGHTEN  = 8'h32;  // '2'

	// full chroma weight: 60*s + 60*(100-s) is always 6000
	localparam logic [W_W-1:0] W_FULL = 13'd6000;
	// floor(y / 625) == (y * RECIP_625) >> 27 for y below 2^18
	localparam logic [MUL_W-1:0] RECIP_625 = 18'd214749;
	localparam int unsigned RECIP_SHIFT = 27;

	typedef enum logic [1:0] {
		COMP_ZERO,
		COMP_X,
		COMP_C
	} comp_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_CONV,
		T_SEND
	} top_state_t;

	typedef enum logic [1:0] {
		CV_IDLE,
		CV_KS,
		CV_VW,
		CV_RC
	} cv_state_t;

	typedef struct packed {
		logic             go;
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] level;
	} cv_req_t;

	typedef struct packed {
		logic            done;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} cv_rsp_t;

	// which component feeds channel ch (0 red, 1 green, 2 blue) in hue sextant sx
	function automatic comp_t comp_sel(input logic [2:0] sx, input logic [1:0] ch);
		comp_t r, g, b, res;
		r = COMP_ZERO;
		g = COMP_ZERO;
		b = COMP_ZERO;
		unique case (sx)
			3'd0: begin r = COMP_C;    g = COMP_X;    b = COMP_ZERO; end
			3'd1: begin r = COMP_X;    g = COMP_C;    b = COMP_ZERO; end
			3'd2: begin r = COMP_ZERO; g = COMP_C;    b = COMP_X;    end
			3'd3: begin r = COMP_ZERO; g = COMP_X;    b = COMP_C;    end
			3'd4: begin r = COMP_X;    g = COMP_ZERO; b = COMP_C;    end
			3'd5: begin r = COMP_C;    g = COMP_ZERO; b = COMP_X;    end
			default: begin r = COMP_ZERO; g = COMP_ZERO; b = COMP_ZERO; end
		endcase
		unique case (ch)
			2'd0: res = r;
			2'd1: res = g;
			2'd2: res = b;
			default: res = COMP_ZERO;
		endcase
		return res;
	endfunction

endpackage

[design/rlhc_if.sv]
// Valid/ready channel interfaces for request items and pixel items.
`timescale 1ns / 1ps

interface rlhc_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] cmd_byte;

	modport source (output valid, output req_type, output cmd_byte, input ready);
	modport sink   (input valid, input req_type, input cmd_byte, output ready);
endinterface

interface rlhc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[design/rlhc_convert.sv]
// HSV to RGB conversion on one shared multiplier under a small sequencer.
`timescale 1ns / 1ps

module rlhc_convert (
	input  logic             clk,
	input  logic             arst_n,
	input  rlhc_pkg::cv_req_t req,
	output rlhc_pkg::cv_rsp_t rsp
);
	import rlhc_pkg::*;

	cv_state_t st_q, st_d;

	logic [5:0]       k_q;
	logic [2:0]       sext_q;
	logic [PCT_W-1:0] sat_q;
	logic [PCT_W-1:0] lvl_q;
	logic [W_W-1:0]   base_q;
	logic [W_W-1:0]   wx_q;
	logic [P_W-1:0]   p_q;
	logic [1:0]       ch_q;
	logic [CH_W-1:0]  red_q, green_q, blue_q;
	logic             done_q;

	// front-end decode of the incoming hue
	logic [HUE_W-1:0] t_in;
	logic [2:0]       sext_in;
	logic [5:0]       k_in;
	logic [PCT_W-1:0] sat_in, lvl_in, inv_sat;
	logic [W_W-1:0]   base_in;

	always_comb begin
		priority if (req.hue < 9'd120) begin
			t_in = req.hue;
		end else if (req.hue < 9'd240) begin
			t_in = req.hue - 9'd120;
		end else begin
			t_in = req.hue - 9'd240;
		end
		priority if (req.hue < 9'd60)       sext_in = 3'd0;
		else if (req.hue < 9'd120)          sext_in = 3'd1;
		else if (req.hue < 9'd180)          sext_in = 3'd2;
		else if (req.hue < 9'd240)          sext_in = 3'd3;
		else if (req.hue < 9'd300)          sext_in = 3'd4;
		else                                sext_in = 3'd5;
		k_in    = (t_in >= 9'd60) ? 6'(9'd120 - t_in) : t_in[5:0];
		sat_in  = (req.sat > PCT_FULL) ? PCT_FULL : req.sat;
		lvl_in  = (req.level > PCT_FULL) ? PCT_FULL : req.level;
		inv_sat = PCT_FULL - sat_in;
		// 60 * (100 - s) as 64x - 4x
		base_in = ({6'd0, inv_sat} << 6) - ({6'd0, inv_sat} << 2);
	end

	// shared multiplier and its operand selection
	comp_t             comp;
	logic [W_W-1:0]    w_sel;
	logic [23:0]       x17;
	logic [MUL_W-1:0]  mul_a, mul_b;
	logic [PROD_W-1:0] mul_p;

	always_comb begin
		comp = comp_sel(sext_q, ch_q);
		unique case (comp)
			COMP_C:    w_sel = W_FULL;
			COMP_X:    w_sel = wx_q;
			COMP_ZERO: w_sel = base_q;
			default:   w_sel = base_q;
		endcase
		// 17 * p, then divide by 64 below
		x17 = ({4'd0, p_q} << 4) + {4'd0, p_q};
		unique case (st_q)
			CV_KS: begin
				mul_a = {12'd0, k_q};
				mul_b = {11'd0, sat_q};
			end
			CV_VW: begin
				mul_a = {5'd0, w_sel};
				mul_b = {11'd0, lvl_q};
			end
			CV_RC: begin
				mul_a = x17[23:6];
				mul_b = RECIP_625;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			CV_IDLE: if (req.go) st_d = CV_KS;
			CV_KS:   st_d = CV_VW;
			CV_VW:   st_d = CV_RC;
			CV_RC:   st_d = (ch_q == 2'd2) ? CV_IDLE : CV_VW;
			default: st_d = CV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= CV_IDLE;
			done_q <= 1'b0;
			ch_q   <= 2'd0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == CV_RC) && (ch_q == 2'd2);
			if (st_q == CV_KS) begin
				ch_q <= 2'd0;
			end else if (st_q == CV_RC) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	logic [CH_W-1:0] ch_val;
	assign ch_val = mul_p[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];

	always_ff @(posedge clk) begin
		if (st_q == CV_IDLE && req.go) begin
			k_q    <= k_in;
			sext_q <= sext_in;
			sat_q  <= sat_in;
			lvl_q  <= lvl_in;
			base_q <= base_in;
		end
		if (st_q == CV_KS) begin
			wx_q <= mul_p[W_W-1:0] + base_q;
		end
		if (st_q == CV_VW) begin
			p_q <= mul_p[P_W-1:0];
		end
		if (st_q == CV_RC) begin
			unique case (ch_q)
				2'd0:    red_q   <= ch_val;
				2'd1:    green_q <= ch_val;
				default: blue_q  <= ch_val;
			endcase
		end
	end

	assign rsp.done  = done_q;
	assign rsp.red   = red_q;
	assign rsp.green = green_q;
	assign rsp.blue  = blue_q;

endmodule

[design/rainbow_led_hsv_controller.sv]
// Top level of the rainbow pixel controller: commands, state, handshakes.
//
//  channel | dir | handshake          | payload
//  req     | in  | valid/ready        | req_type, cmd_byte
//  pix     | out | valid/ready        | red, green, blue
//  cfg     | in  | cfg_wr_en, no wait | cfg_index, cfg_data
//
// A command item is taken while idle and gives no result.
// A lit frame tick makes seven passes through the single shared
// multiplier (one for k*s, two per channel), plus hand-over.
// A dark tick skips the converter and loads black in the send state.
// req.ready is high only while idle; a finished pixel waits in the output
// register, and a new item may be taken while it does. Reset is immediate.
`timescale 1ns / 1ps

module rainbow_led_hsv_controller (
	input  logic                           clk,
	input  logic                           arst_n,
	rlhc_req_if.sink                       req,
	rlhc_pix_if.source                     pix,
	input  logic                           cfg_wr_en,
	input  logic [rlhc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rlhc_pkg::CFG_W-1:0]     cfg_data
);
	import rlhc_pkg::*;

	top_state_t st_q, st_d;

	logic [HUE_W-1:0] hue_step_q;
	logic [PCT_W-1:0] sat_q;
	logic [PCT_W-1:0] bstep_q;
	logic [HUE_W-1:0] hue_q;
	logic [PCT_W-1:0] level_q;
	logic             lit_q;
	logic             dark_q;
	logic             pix_valid_q;
	logic [CH_W-1:0]  red_q, green_q, blue_q;

	cv_req_t cv_req;
	cv_rsp_t cv_rsp;

	logic accept, is_tick, out_free;

	assign accept   = req.valid && req.ready;
	assign is_tick  = req.req_type;
	assign out_free = !pix_valid_q || pix.ready;

	assign req.ready = (st_q == T_IDLE);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			T_IDLE: begin
				if (accept && is_tick) st_d = lit_q ? T_CONV : T_SEND;
			end
			T_CONV: if (cv_rsp.done) st_d = T_SEND;
			T_SEND: if (out_free) st_d = T_IDLE;
			default: st_d = T_IDLE;
		endcase
	end

	assign cv_req.go    = accept && is_tick && lit_q;
	assign cv_req.hue   = hue_q;
	assign cv_req.sat   = sat_q;
	assign cv_req.level = level_q;

	rlhc_convert u_convert (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cv_req),
		.rsp    (cv_rsp)
	);

	// next hue, sum stays below 720 + 360 so two conditional subtracts suffice
	logic [HUE_W:0] hue_sum, hue_nxt;
	always_comb begin
		hue_sum = {1'b0, hue_q} + {1'b0, hue_step_q};
		priority if (hue_sum >= 10'd720)      hue_nxt = hue_sum - 10'd720;
		else if (hue_sum >= 10'd360)          hue_nxt = hue_sum - 10'd360;
		else                                  hue_nxt = hue_sum;
	end

	logic [PCT_W:0] level_up;
	assign level_up = {1'b0, level_q} + {1'b0, bstep_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_IDLE;
			hue_step_q  <= HUE_STEP_RST;
			sat_q       <= SAT_RST;
			bstep_q     <= BSTEP_RST;
			hue_q       <= '0;
			level_q     <= LEVEL_RST;
			lit_q       <= 1'b1;
			dark_q      <= 1'b0;
			pix_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_HUE_STEP:        hue_step_q <= cfg_data[HUE_W-1:0];
					REG_SATURATION:      sat_q      <= cfg_data[PCT_W-1:0];
					REG_BRIGHTNESS_STEP: bstep_q    <= cfg_data[PCT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (is_tick) begin
					dark_q <= !lit_q;
					if (lit_q) hue_q <= hue_nxt[HUE_W-1:0];
				end else begin
					priority if (req.cmd_byte == CMD_TOGGLE_LC ||
							req.cmd_byte == CMD_TOGGLE_UC) begin
						lit_q <= !lit_q;
					end else if (req.cmd_byte == CMD_DIM) begin
						level_q <= (level_q > bstep_q) ? level_q - bstep_q : '0;
					end else if (req.cmd_byte == CMD_BRIGHTEN) begin
						if (level_q < PCT_FULL) begin
							level_q <= (level_up > {1'b0, PCT_FULL}) ? PCT_FULL
								: level_up[PCT_W-1:0];
						end
					end
				end
			end
			if (st_q == T_SEND && out_free) begin
				pix_valid_q <= 1'b1;
			end else if (pix.ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == T_SEND && out_free) begin
			red_q   <= dark_q ? '0 : cv_rsp.red;
			green_q <= dark_q ? '0 : cv_rsp.green;
			blue_q  <= dark_q ? '0 : cv_rsp.blue;
		end
	end

	assign pix.valid = pix_valid_q;
	assign pix.red   = red_q;
	assign pix.green = green_q;
	assign pix.blue  = blue_q;

endmodule
